>>> rtl/lp2c_pkg.sv
package lp2c_pkg;

    // Measurement as it arrives from the scanner
    typedef struct packed {
        logic [15:0] angle_raw;
        logic [17:0] distance_raw;
        logic [7:0]  quality_raw;
        logic        scan_end;
    } meas_t;

    // Converted point
    typedef struct packed {
        logic signed [18:0] phi;
        logic [22:0]        range_m;
        logic signed [23:0] x_pos;
        logic signed [23:0] y_pos;
        logic [7:0]         strength;
        logic               point_valid;
        logic               scan_end_out;
    } point_t;

    // Fields that ride along the rotation stages
    typedef struct packed {
        logic signed [18:0] phi;
        logic [22:0]        range_m;
        logic [7:0]         strength;
        logic               nz;
        logic               scan_end;
    } side_t;

    localparam int PADDR_W = 3;
    localparam logic REG_QUALITY_SHIFT = 1'b0;   // word index of quality_shift
    localparam logic [2:0] QSHIFT_RESET = 3'd2;

    // 2*pi in Q32, split so each partial product stays narrow
    localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
    localparam logic [16:0] TWO_PI_HI  = TWO_PI_Q32[34:18];
    localparam logic [17:0] TWO_PI_LO  = TWO_PI_Q32[17:0];

    // ceil(2^37 / 125): exact quotient for numerators below 2^30
    localparam logic [30:0] RECIP_125 = 31'd1099511628;

    // inverse CORDIC gain, Q30
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam int XY_W  = 33;
    localparam int Z_W   = 32;
    localparam int GUARD = 8;
    localparam int TABLE_LEN = 24;

    localparam logic signed [XY_W-1:0] XY_LIMIT = 33'sd4294967;

    // atan(2^-i) as a fraction of a turn, 2^32 = full turn
    localparam logic signed [Z_W-1:0] ATAN_TURN [TABLE_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10680350,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

endpackage

>>> rtl/lidar_polar_to_cartesian.sv
// Channel    Direction  Handshake              Payload
// meas       in         meas_valid/meas_ready  lp2c_pkg::meas_t
// pt         out        pt_valid/pt_ready      lp2c_pkg::point_t
// apb        in/out     psel/penable/pready    quality_shift at byte address 0
//
// One measurement per cycle while the skid buffer is empty; each result passes
// through four stages (angle fold and partial products, phi and range, gain
// product, start vector), one register stage per CORDIC rotation and one rounding stage.
// rst_n clears all valid bits and sets quality_shift to 2.
// A stalled result moves into a one-entry skid buffer; the pipeline holds
// while that buffer is full.
module lidar_polar_to_cartesian #(
    parameter int CORDIC_STAGES = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          meas_valid,
    output logic                          meas_ready,
    input  lp2c_pkg::meas_t               meas_data,
    output logic                          pt_valid,
    input  logic                          pt_ready,
    output lp2c_pkg::point_t              pt_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lp2c_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int LAST = CORDIC_STAGES + 4;
    localparam int XW   = lp2c_pkg::XY_W;
    localparam int ZW   = lp2c_pkg::Z_W;

    // ---------------- configuration ----------------
    logic [2:0] qshift_reg;
    logic [2:0] qshift_next;

    assign pready = 1'b1;

    always_comb
    begin
        qshift_next = qshift_reg;
        if (psel && penable && pwrite && paddr[2] == lp2c_pkg::REG_QUALITY_SHIFT)
        begin
            qshift_next = pwdata[2:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lp2c_pkg::REG_QUALITY_SHIFT)
        begin
            prdata = {29'd0, qshift_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qshift_reg <= lp2c_pkg::QSHIFT_RESET;
        end
        else
        begin
            qshift_reg <= qshift_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic            en;
    logic [LAST:0]   v_reg;
    logic [LAST:0]   v_next;
    logic            skid_v_reg;
    logic            skid_v_next;
    lp2c_pkg::point_t skid_reg;
    lp2c_pkg::point_t out_reg;
    lp2c_pkg::point_t out_next;

    assign en         = !skid_v_reg;
    assign meas_ready = en;
    assign v_next     = {v_reg[LAST-1:0], meas_valid};
    assign pt_valid   = skid_v_reg || v_reg[LAST];
    assign pt_data    = skid_v_reg ? skid_reg : out_reg;

    always_comb
    begin
        if (skid_v_reg)
        begin
            skid_v_next = !pt_ready;
        end
        else
        begin
            skid_v_next = v_reg[LAST] && !pt_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            skid_v_reg <= skid_v_next;
            if (en)
            begin
                v_reg <= v_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_reg <= out_reg;
        end
    end

    // ---------------- stage 0: angle fold, partial products ----------------
    logic signed [16:0] d_s;
    logic [16:0]        mag;
    logic signed [15:0] b_s;
    logic               fold;
    logic [29:0]        num;

    logic [33:0]        ph_hi_reg, ph_hi_next;
    logic [34:0]        ph_lo_reg, ph_lo_next;
    logic [60:0]        rprod_reg, rprod_next;
    logic               neg_reg;
    logic [7:0]         str0_reg;
    logic               nz0_reg;
    logic               se0_reg;
    logic signed [15:0] bf_reg   [0:2];
    logic               flip_reg [0:2];
    logic signed [15:0] bf_next;

    always_comb
    begin
        d_s  = $signed({1'b0, 16'h8000}) - $signed({1'b0, meas_data.angle_raw});
        mag  = d_s[16] ? 17'(-d_s) : 17'(d_s);
        b_s  = d_s[15:0];
        // beyond a quarter turn: rotate by a half turn and negate the start vector
        fold = (b_s > 16'sd16384) || (b_s < -16'sd16384);
        bf_next = fold ? {~b_s[15], b_s[14:0]} : b_s;
        num  = {1'b0, meas_data.distance_raw, 11'd0} + 30'd62;
        ph_hi_next = mag * lp2c_pkg::TWO_PI_HI;
        ph_lo_next = mag * lp2c_pkg::TWO_PI_LO;
        rprod_next = num * lp2c_pkg::RECIP_125;
    end

    // ---------------- stage 1: phi and range ----------------
    logic [51:0]        psum;
    logic [17:0]        pm;
    lp2c_pkg::side_t    side1_next;

    always_comb
    begin
        psum = {ph_hi_reg, 18'd0} + 52'(ph_lo_reg) + 52'h0_0000_8000_0000;
        pm   = psum[49:32];
        side1_next.phi      = neg_reg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
        side1_next.range_m  = rprod_reg[59:37];
        side1_next.strength = str0_reg;
        side1_next.nz       = nz0_reg;
        side1_next.scan_end = se0_reg;
    end

    // ---------------- stage 2: gain product ----------------
    lp2c_pkg::side_t side_reg [1:LAST-1];
    logic [52:0]     gprod_reg, gprod_next;

    assign gprod_next = side_reg[1].range_m * lp2c_pkg::GAIN_Q30;

    // ---------------- stage 3: start vector ----------------
    logic [52:0]          gsum;
    logic [30:0]          cmag;
    logic signed [XW-1:0] x_reg [3:LAST-1];
    logic signed [XW-1:0] y_reg [3:LAST-1];
    logic signed [ZW-1:0] z_reg [3:LAST-1];
    logic signed [XW-1:0] x_next [3:LAST-1];
    logic signed [XW-1:0] y_next [3:LAST-1];
    logic signed [ZW-1:0] z_next [3:LAST-1];

    always_comb
    begin
        gsum = gprod_reg + 53'd2097152;
        cmag = gsum[52:22];
    end

    // ---------------- rotation stages ----------------
    always_comb
    begin
        logic signed [XW-1:0] sx;
        logic signed [XW-1:0] sy;
        x_next[3] = flip_reg[2] ? -$signed({2'b0, cmag}) : $signed({2'b0, cmag});
        y_next[3] = '0;
        z_next[3] = {bf_reg[2], 16'd0};
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            sx = x_reg[3+i] >>> i;
            sy = y_reg[3+i] >>> i;
            if (!z_reg[3+i][ZW-1])
            begin
                x_next[4+i] = x_reg[3+i] - sy;
                y_next[4+i] = y_reg[3+i] + sx;
                z_next[4+i] = z_reg[3+i] - lp2c_pkg::ATAN_TURN[i];
            end
            else
            begin
                x_next[4+i] = x_reg[3+i] + sy;
                y_next[4+i] = y_reg[3+i] - sx;
                z_next[4+i] = z_reg[3+i] + lp2c_pkg::ATAN_TURN[i];
            end
        end
    end

    // ---------------- output stage: round, clamp, blank ----------------
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    logic signed [23:0]   xc;
    logic signed [23:0]   yc;
    lp2c_pkg::side_t      sl;

    always_comb
    begin
        sl = side_reg[LAST-1];
        xr = (x_reg[LAST-1] + XW'(128)) >>> lp2c_pkg::GUARD;
        yr = (y_reg[LAST-1] + XW'(128)) >>> lp2c_pkg::GUARD;
        if (xr > lp2c_pkg::XY_LIMIT)
        begin
            xc = 24'(lp2c_pkg::XY_LIMIT);
        end
        else if (xr < -lp2c_pkg::XY_LIMIT)
        begin
            xc = 24'(-lp2c_pkg::XY_LIMIT);
        end
        else
        begin
            xc = xr[23:0];
        end
        if (yr > lp2c_pkg::XY_LIMIT)
        begin
            yc = 24'(lp2c_pkg::XY_LIMIT);
        end
        else if (yr < -lp2c_pkg::XY_LIMIT)
        begin
            yc = 24'(-lp2c_pkg::XY_LIMIT);
        end
        else
        begin
            yc = yr[23:0];
        end
        out_next              = '0;
        out_next.scan_end_out = sl.scan_end;
        if (sl.nz)
        begin
            out_next.phi         = sl.phi;
            out_next.range_m     = sl.range_m;
            out_next.x_pos       = xc;
            out_next.y_pos       = yc;
            out_next.strength    = sl.strength;
            out_next.point_valid = 1'b1;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_hi_reg   <= ph_hi_next;
            ph_lo_reg   <= ph_lo_next;
            rprod_reg   <= rprod_next;
            neg_reg     <= d_s[16];
            str0_reg    <= meas_data.quality_raw >> qshift_reg;
            nz0_reg     <= (meas_data.distance_raw != '0);
            se0_reg     <= meas_data.scan_end;
            bf_reg[0]   <= bf_next;
            flip_reg[0] <= fold;
            for (int k = 1; k < 3; k++)
            begin
                bf_reg[k]   <= bf_reg[k-1];
                flip_reg[k] <= flip_reg[k-1];
            end
            side_reg[1] <= side1_next;
            gprod_reg   <= gprod_next;
            for (int k = 2; k < LAST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 3; k < LAST; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            out_reg <= out_next;
        end
    end

    // ---------------- assertions ----------------
    a_blank_no_return: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_data.point_valid |->
            pt_data.x_pos == '0 && pt_data.y_pos == '0 && pt_data.phi == '0 &&
            pt_data.range_m == '0 && pt_data.strength == '0)
        else $error("blank point carries nonzero fields");

    a_xy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid |->
            pt_data.x_pos <= 24'sd4294967 && pt_data.x_pos >= -24'sd4294967 &&
            pt_data.y_pos <= 24'sd4294967 && pt_data.y_pos >= -24'sd4294967)
        else $error("x or y outside clamp range");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && pt_ready |=> !skid_v_reg)
        else $error("skid buffer did not drain");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_v_reg && v_reg[LAST] && !pt_ready |=>
            skid_v_reg && skid_reg == $past(out_reg))
        else $error("stalled result not captured");

endmodule
